FILE: design/sgb_pkg.sv
// Shared types and constants of the separable Gaussian blur.
// Used by the top level separable_gaussian_blur; depends on nothing.
package sgb_pkg;

    // Window geometry: the datapath is laid out for a 5x5 window.
    localparam int KERNEL_RADIUS = 2;
    localparam int ROWS_KEPT     = 2 * KERNEL_RADIUS + 1;

    localparam int PIX_W    = 8;
    localparam int TAP_W    = 16;
    localparam int CFG_W    = 11;
    localparam int OUT_W    = 16;
    localparam int SLOT_W   = 3;
    localparam int ROW_W    = 11;
    localparam int HLAST_W  = 10;
    localparam int HEIGHT_LIMIT = 1024;

    // Configuration port.
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Vertical and horizontal arithmetic widths.
    localparam int VPAIR_W = PIX_W + 1;
    localparam int VPROD_W = VPAIR_W + TAP_W;
    localparam int VSUM_W  = VPROD_W + 2;
    localparam int HPAIR_W = VSUM_W + 1;
    localparam int HPROD_W = HPAIR_W + TAP_W;
    localparam int HSUM_W  = HPROD_W + 2;
    localparam int ROUND_SHIFT = 24;
    localparam int SCALED_W    = HSUM_W - ROUND_SHIFT;
    localparam logic [HSUM_W-1:0] ROUND_ADD = HSUM_W'(1) << (ROUND_SHIFT - 1);

    // Result queue.
    localparam int RES_DEPTH = 16;
    localparam int RES_PTR_W = 4;
    localparam int RES_CNT_W = 5;

    // Register reset values.
    localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;
    localparam logic [TAP_W-1:0] CENTER_RESET = 16'd19142;
    localparam logic [TAP_W-1:0] NEAR_RESET   = 16'd15328;
    localparam logic [TAP_W-1:0] FAR_RESET    = 16'd7869;

    typedef enum logic [2:0] {
        REG_WIDTH  = 3'd0,
        REG_HEIGHT = 3'd1,
        REG_CENTER = 3'd2,
        REG_NEAR   = 3'd3,
        REG_FAR    = 3'd4
    } reg_index_t;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } op_t;

    // One column of the line store: one byte per kept row.
    typedef logic [ROWS_KEPT-1:0][PIX_W-1:0] word_t;

    // What the horizontal stage must do with one column sum.
    typedef struct packed {
        logic       first;
        logic       last;
        logic       out_row;
        logic       mid;
        logic [1:0] pre;
        logic       flast;
    } step_t;

    typedef struct packed {
        logic emit;
        logic row_end;
        logic frame_end;
    } mark_t;

    typedef struct packed {
        logic [OUT_W-1:0] blurred;
        logic             row_end;
        logic             frame_end;
    } res_t;

endpackage

FILE: design/separable_gaussian_blur.sv
// Streaming 5x5 separable Gaussian blur with replicated borders.
// Depends on sgb_pkg and the line store RAM sgb_ram.
//
// Usage. Requests arrive on the pix channel (pix_valid, pix_stall, operation, pixel)
// in raster order: one pixel request per pixel of the frame, then 2*W drain requests
// that stand for the replicated rows below the frame. Results leave on the res
// channel (res_valid, res_stall, blurred, row_end, frame_end), one blurred 8.8 value
// per pixel, in raster order, with row_end on the last column and frame_end on the
// last pixel. Width, height and the three Q0.16 taps are written through the APB
// port while the block is idle; a size write returns the frame position to the start.
// Throughput: one request per cycle while the result queue has room, except that the
// last request of each row holds the pix channel while the horizontal window
// replicates the right border. A request that completes an output passes through
// the line store stage A, the vertical stages B and C, the window stage and the
// horizontal stages E to G before its result enters the queue.
// Reset clears the frame position, the pipeline and the result queue and loads the
// default registers; the line store is not cleared, as every entry read in a frame
// has been written earlier in that frame. When the receiver stalls, results collect
// in a 16-entry queue; the pix channel stalls once the queue and the results still
// in flight could overflow it.
module separable_gaussian_blur
    import sgb_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              pix_valid,
    output logic              pix_stall,
    input  logic              operation,
    input  logic [PIX_W-1:0]  pixel,
    output logic              res_valid,
    input  logic              res_stall,
    output logic [OUT_W-1:0]  blurred,
    output logic              row_end,
    output logic              frame_end
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WB = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;

    // ---------------------------------------------------------------- registers
    logic [CFG_W-1:0] width_reg, height_reg;
    logic [TAP_W-1:0] center_reg, near_reg, far_reg;
    logic             cfg_wr;
    reg_index_t       cfg_idx;
    logic             size_wr;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_index_t'(paddr[ADDR_W-1:2]);
    assign size_wr = cfg_wr && (cfg_idx == REG_WIDTH || cfg_idx == REG_HEIGHT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            center_reg <= CENTER_RESET;
            near_reg   <= NEAR_RESET;
            far_reg    <= FAR_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_WIDTH:  width_reg  <= pwdata[CFG_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[CFG_W-1:0];
                REG_CENTER: center_reg <= pwdata[TAP_W-1:0];
                REG_NEAR:   near_reg   <= pwdata[TAP_W-1:0];
                REG_FAR:    far_reg    <= pwdata[TAP_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_WIDTH:  prdata = DATA_W'(width_reg);
            REG_HEIGHT: prdata = DATA_W'(height_reg);
            REG_CENTER: prdata = DATA_W'(center_reg);
            REG_NEAR:   prdata = DATA_W'(near_reg);
            REG_FAR:    prdata = DATA_W'(far_reg);
            default:    prdata = '0;
        endcase
    end

    // Last valid column and row after clamping the programmed sizes.
    logic [WB-1:0]      width_ext, max_w;
    logic [WB-1:0]      wlast_full;
    logic [CW-1:0]      wlast;
    logic [HLAST_W-1:0] hlast;
    logic [ROW_W-1:0]   hlast_ext;

    assign width_ext = WB'(width_reg);
    assign max_w     = WB'(MAX_WIDTH);

    always_comb
    begin
        priority if (width_ext == '0)
            wlast_full = '0;
        else if (width_ext > max_w)
            wlast_full = max_w - 1'b1;
        else
            wlast_full = width_ext - 1'b1;

        priority if (height_reg == '0)
            hlast = '0;
        else if (height_reg > CFG_W'(HEIGHT_LIMIT))
            hlast = HLAST_W'(HEIGHT_LIMIT - 1);
        else
            hlast = HLAST_W'(height_reg - 1'b1);
    end

    assign wlast     = wlast_full[CW-1:0];
    assign hlast_ext = ROW_W'(hlast);

    // ---------------------------------------------------------- frame position
    logic [CW-1:0]     col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [1:0]        hold_reg, hold_next;
    logic [RES_CNT_W-1:0] resv_reg, resv_next;

    logic              accept, is_pix, in_drain, restart_px, launch, at_last_col;
    logic [CW-1:0]     cur_col;
    logic [ROW_W-1:0]  cur_row;
    logic [SLOT_W-1:0] cur_slot;
    logic [SLOT_W-1:0] over, ycap, back;
    logic [ROWS_KEPT-1:0][SLOT_W-1:0] sel_next;
    step_t             step_next;
    logic [1:0]        nres;

    assign pix_stall = (hold_reg != '0) || (resv_reg > RES_CNT_W'(RES_DEPTH - 3));
    assign accept    = pix_valid && !pix_stall;
    assign is_pix    = (op_t'(operation) == OP_PIXEL);
    assign in_drain  = row_reg > hlast_ext;
    // A pixel during a drain abandons it and opens a new frame.
    assign restart_px = is_pix && in_drain;
    // A drain request inside the frame is taken and dropped.
    assign launch     = accept && (is_pix || in_drain);

    assign cur_col  = restart_px ? '0 : col_reg;
    assign cur_row  = restart_px ? '0 : row_reg;
    assign cur_slot = restart_px ? '0 : slot_reg;
    assign at_last_col = (cur_col == wlast);

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        slot_next = slot_reg;
        if (size_wr)
        begin
            col_next  = '0;
            row_next  = '0;
            slot_next = '0;
        end
        else if (launch)
        begin
            if (at_last_col)
            begin
                col_next  = '0;
                row_next  = cur_row + 1'b1;
                slot_next = (cur_slot == SLOT_W'(ROWS_KEPT - 1)) ? '0 : cur_slot + 1'b1;
                if (!is_pix && (cur_row == hlast_ext + ROW_W'(KERNEL_RADIUS)))
                begin
                    row_next  = '0;
                    slot_next = '0;
                end
            end
            else
            begin
                col_next  = cur_col + 1'b1;
                row_next  = cur_row;
                slot_next = cur_slot;
            end
        end
    end

    // Line store slots of the five window rows, clamped to the frame.
    always_comb
    begin
        over = (cur_row > hlast_ext) ? SLOT_W'(cur_row - hlast_ext) : '0;
        ycap = (cur_row > ROW_W'(ROWS_KEPT - 1)) ? SLOT_W'(ROWS_KEPT - 1)
                                                  : cur_row[SLOT_W-1:0];
        back = '0;
        for (int k = 0; k < ROWS_KEPT; k++)
        begin
            back = SLOT_W'(ROWS_KEPT - 1 - k);
            if (back < over)
                back = over;
            if (back > ycap)
                back = ycap;
            sel_next[k] = (cur_slot >= back) ? cur_slot - back
                                             : cur_slot + SLOT_W'(ROWS_KEPT) - back;
        end
    end

    always_comb
    begin
        step_next.first   = (cur_col == '0);
        step_next.last    = at_last_col;
        step_next.out_row = cur_row >= ROW_W'(KERNEL_RADIUS);
        step_next.mid     = (cur_col >= CW'(KERNEL_RADIUS)) && !at_last_col;
        step_next.flast   = (cur_row == hlast_ext + ROW_W'(KERNEL_RADIUS));
        priority if (wlast == '0)
            step_next.pre = 2'd2;
        else if (wlast == CW'(1))
            step_next.pre = 2'd1;
        else
            step_next.pre = 2'd0;

        priority if (!step_next.out_row)
            nres = 2'd0;
        else if (at_last_col)
            nres = 2'd3 - step_next.pre;
        else if (step_next.mid)
            nres = 2'd1;
        else
            nres = 2'd0;
    end

    // At the row end the pix channel is held while the horizontal stage replicates the border.
    always_comb
    begin
        if (launch && at_last_col)
            hold_next = 2'd2;
        else if (hold_reg != '0)
            hold_next = hold_reg - 1'b1;
        else
            hold_next = '0;
    end

    // ----------------------------------------------------- line store (stage A)
    logic              a_valid_reg, a_pix_reg, fwd_reg;
    logic [CW-1:0]     a_col_reg;
    logic [SLOT_W-1:0] a_slot_reg;
    logic [PIX_W-1:0]  a_pixel_reg;
    logic [ROWS_KEPT-1:0][SLOT_W-1:0] a_sel_reg;
    step_t             a_step_reg;
    word_t             ram_rdata, merged, last_w_reg;
    logic              ram_we;

    assign ram_we = a_valid_reg && a_pix_reg;

    sgb_ram #(
        .WIDTH ($bits(word_t)),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (a_col_reg),
        .wdata (merged),
        .raddr (cur_col),
        .rdata (ram_rdata)
    );

    // The word written at the same edge as this read is not yet in the read data.
    always_comb
    begin
        merged = fwd_reg ? last_w_reg : ram_rdata;
        if (a_pix_reg)
            merged[a_slot_reg] = a_pixel_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            fwd_reg     <= 1'b0;
        end
        else
        begin
            a_valid_reg <= launch;
            fwd_reg     <= ram_we && (a_col_reg == cur_col);
        end
    end

    always_ff @(posedge clk)
    begin
        last_w_reg  <= merged;
        a_pix_reg   <= is_pix;
        a_col_reg   <= cur_col;
        a_slot_reg  <= cur_slot;
        a_pixel_reg <= pixel;
        a_sel_reg   <= sel_next;
        a_step_reg  <= step_next;
    end

    // ---------------------------------------------- vertical filter (stages B, C)
    logic               b_valid_reg, c_valid_reg;
    step_t              b_step_reg, c_step_reg;
    logic [VPAIR_W-1:0] b_far_reg, b_near_reg, b_ctr_reg;
    logic [VPROD_W-1:0] c_far_reg, c_near_reg, c_ctr_reg;
    logic [PIX_W-1:0]   v0, v1, v2, v3, v4;

    assign v0 = merged[a_sel_reg[0]];
    assign v1 = merged[a_sel_reg[1]];
    assign v2 = merged[a_sel_reg[2]];
    assign v3 = merged[a_sel_reg[3]];
    assign v4 = merged[a_sel_reg[4]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b_step_reg <= a_step_reg;
        b_far_reg  <= VPAIR_W'(v0) + VPAIR_W'(v4);
        b_near_reg <= VPAIR_W'(v1) + VPAIR_W'(v3);
        b_ctr_reg  <= VPAIR_W'(v2);
        c_step_reg <= b_step_reg;
        c_far_reg  <= VPROD_W'(b_far_reg) * VPROD_W'(far_reg);
        c_near_reg <= VPROD_W'(b_near_reg) * VPROD_W'(near_reg);
        c_ctr_reg  <= VPROD_W'(b_ctr_reg) * VPROD_W'(center_reg);
    end

    // ------------------------------------------------ horizontal window stage
    logic [VSUM_W-1:0] vsum;
    logic [VSUM_W-1:0] win_reg [ROWS_KEPT];
    logic [VSUM_W-1:0] win_next [ROWS_KEPT];
    logic [1:0]        tail_reg, tail_next;
    logic [1:0]        tpre_reg, tpre_next;
    logic              trow_reg, trow_next, tflast_reg, tflast_next;
    mark_t             w_mark_reg, w_mark_next;

    assign vsum = VSUM_W'(c_far_reg) + VSUM_W'(c_near_reg) + VSUM_W'(c_ctr_reg);

    // Window entry 2 is the output column; the right border is replicated by
    // shifting the newest column sum in again after the row end.
    always_comb
    begin
        for (int j = 0; j < ROWS_KEPT; j++)
            win_next[j] = win_reg[j];
        tail_next   = tail_reg;
        tpre_next   = tpre_reg;
        trow_next   = trow_reg;
        tflast_next = tflast_reg;
        w_mark_next = '0;
        if (c_valid_reg)
        begin
            for (int j = 0; j < ROWS_KEPT - 1; j++)
                win_next[j] = c_step_reg.first ? vsum : win_reg[j + 1];
            win_next[ROWS_KEPT - 1] = vsum;
            w_mark_next.emit = c_step_reg.out_row &&
                               (c_step_reg.last ? (c_step_reg.pre == 2'd0) : c_step_reg.mid);
            tail_next   = c_step_reg.last ? 2'd2 : 2'd0;
            tpre_next   = c_step_reg.pre;
            trow_next   = c_step_reg.out_row;
            tflast_next = c_step_reg.flast;
        end
        else if (tail_reg != '0)
        begin
            for (int j = 0; j < ROWS_KEPT - 1; j++)
                win_next[j] = win_reg[j + 1];
            win_next[ROWS_KEPT - 1] = win_reg[ROWS_KEPT - 1];
            w_mark_next.emit      = trow_reg && ((tail_reg == 2'd1) || (tpre_reg != 2'd2));
            w_mark_next.row_end   = trow_reg && (tail_reg == 2'd1);
            w_mark_next.frame_end = trow_reg && (tail_reg == 2'd1) && tflast_reg;
            tail_next = tail_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tail_reg   <= '0;
            w_mark_reg <= '0;
        end
        else
        begin
            tail_reg   <= tail_next;
            w_mark_reg <= w_mark_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < ROWS_KEPT; j++)
            win_reg[j] <= win_next[j];
        tpre_reg   <= tpre_next;
        trow_reg   <= trow_next;
        tflast_reg <= tflast_next;
    end

    // ------------------------------------------ horizontal filter (stages E-G)
    mark_t              e_mark_reg, f_mark_reg, g_mark_reg;
    logic [HPAIR_W-1:0] e_far_reg, e_near_reg, e_ctr_reg;
    logic [HPROD_W-1:0] f_far_reg, f_near_reg, f_ctr_reg;
    logic [HSUM_W-1:0]  g_sum_reg;
    logic [SCALED_W-1:0] scaled;
    res_t               res_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_mark_reg <= '0;
            f_mark_reg <= '0;
            g_mark_reg <= '0;
        end
        else
        begin
            e_mark_reg <= w_mark_reg;
            f_mark_reg <= e_mark_reg;
            g_mark_reg <= f_mark_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        e_far_reg  <= HPAIR_W'(win_reg[0]) + HPAIR_W'(win_reg[4]);
        e_near_reg <= HPAIR_W'(win_reg[1]) + HPAIR_W'(win_reg[3]);
        e_ctr_reg  <= HPAIR_W'(win_reg[2]);
        f_far_reg  <= HPROD_W'(e_far_reg) * HPROD_W'(far_reg);
        f_near_reg <= HPROD_W'(e_near_reg) * HPROD_W'(near_reg);
        f_ctr_reg  <= HPROD_W'(e_ctr_reg) * HPROD_W'(center_reg);
        g_sum_reg  <= HSUM_W'(f_far_reg) + HSUM_W'(f_near_reg) + HSUM_W'(f_ctr_reg) + ROUND_ADD;
    end

    // Round half up to 8.8 and saturate.
    assign scaled = g_sum_reg[HSUM_W-1:ROUND_SHIFT];
    always_comb
    begin
        res_word.blurred   = (|scaled[SCALED_W-1:OUT_W]) ? {OUT_W{1'b1}} : scaled[OUT_W-1:0];
        res_word.row_end   = g_mark_reg.row_end;
        res_word.frame_end = g_mark_reg.frame_end;
    end

    // ------------------------------------------------------------ result queue
    res_t                 fifo_mem_reg [RES_DEPTH];
    logic [RES_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [RES_CNT_W-1:0] fifo_cnt_reg;
    logic                 push, pop;

    assign push      = g_mark_reg.emit;
    assign res_valid = (fifo_cnt_reg != '0);
    assign pop       = res_valid && !res_stall;
    assign blurred   = fifo_mem_reg[rd_ptr_reg].blurred;
    assign row_end   = fifo_mem_reg[rd_ptr_reg].row_end;
    assign frame_end = fifo_mem_reg[rd_ptr_reg].frame_end;

    // Slots held for results still in the pipeline, plus those queued.
    always_comb
    begin
        resv_next = resv_reg + (launch ? RES_CNT_W'(nres) : '0) - (pop ? 1'b1 : 1'b0);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_mem_reg[wr_ptr_reg] <= res_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            slot_reg     <= '0;
            hold_reg     <= '0;
            resv_reg     <= '0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            slot_reg <= slot_next;
            hold_reg <= hold_next;
            resv_reg <= resv_next;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            fifo_cnt_reg <= fifo_cnt_reg + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
        end
    end

    // -------------------------------------------------------------- assertions
    // A new column sum never meets the border replication of the previous row.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(c_valid_reg && (tail_reg != '0)))
        else $error("column sum arrived during row end replication");

    // Every queued result was reserved at request time.
    assert property (@(posedge clk) disable iff (!rst_n)
        fifo_cnt_reg <= resv_reg)
        else $error("result queue holds more than was reserved");

    // The queue never overflows.
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (fifo_cnt_reg < RES_CNT_W'(RES_DEPTH)) || pop)
        else $error("result queue overflow");

endmodule

FILE: design/sgb_ram.sv
// Generic single-clock RAM, one write port and one read port, registered read.
// Stands alone; used for the line store of separable_gaussian_blur.
module sgb_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: dv/separable_gaussian_blur_tb.sv
// Self-checking testbench for separable_gaussian_blur: directed rows, then random frames.
// Depends on sgb_pkg and the design; outputs are checked against an in-bench predictor.
`timescale 1ns / 100ps

module separable_gaussian_blur_tb;
    import sgb_pkg::*;

    localparam int LINE_MAX    = 1024;
    localparam int SETTLE      = 24;
    localparam int RANDOM_REQS = 210;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              pix_valid;
    logic              pix_stall;
    logic              operation;
    logic [PIX_W-1:0]  pixel;
    logic              res_valid;
    logic              res_stall;
    logic [OUT_W-1:0]  blurred;
    logic              row_end;
    logic              frame_end;

    separable_gaussian_blur i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .operation (operation),
        .pixel     (pixel),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .blurred   (blurred),
        .row_end   (row_end),
        .frame_end (frame_end)
    );

    // Clock with a 10 ns period.
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Shadow copy of the block: line store, frame position and registers.
    logic [PIX_W-1:0] line_rows [ROWS_KEPT][LINE_MAX];
    int unsigned      col_pos;
    int unsigned      row_pos;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [TAP_W-1:0] centre_tap;
    logic [TAP_W-1:0] near_tap;
    logic [TAP_W-1:0] far_tap;

    res_t pending_blur[$];
    int   fail_count;
    int   mismatch_count;
    int   sender_idle_pct;
    int   receiver_stall_pct;
    int   requests_sent;

    function automatic int frame_width();
        if (width_reg < 1) return 1;
        if (width_reg > LINE_MAX) return LINE_MAX;
        return int'(width_reg);
    endfunction

    function automatic int frame_height();
        if (height_reg < 1) return 1;
        if (height_reg > HEIGHT_LIMIT) return HEIGHT_LIMIT;
        return int'(height_reg);
    endfunction

    function automatic longint unsigned weight(int d);
        if (d < 0) d = -d;
        if (d == 0) return longint'(centre_tap);
        if (d == 1) return longint'(near_tap);
        return longint'(far_tap);
    endfunction

    function automatic int edge_clamp(int v, int hi);
        if (v < 0) return 0;
        if (v > hi) return hi;
        return v;
    endfunction

    // Exact window sum, rounded half up to 8.8 and saturated.
    function automatic logic [OUT_W-1:0] window_blur(int r, int c, int w, int h);
        longint unsigned total;
        longint unsigned line_sum;
        int rr;
        int cc;
        total = 0;
        for (int i = -KERNEL_RADIUS; i <= KERNEL_RADIUS; i++)
        begin
            rr = edge_clamp(r + i, h - 1);
            line_sum = 0;
            for (int j = -KERNEL_RADIUS; j <= KERNEL_RADIUS; j++)
            begin
                cc = edge_clamp(c + j, w - 1);
                line_sum += weight(j) * longint'(line_rows[rr % ROWS_KEPT][cc]);
            end
            total += weight(i) * line_sum;
        end
        total = (total + (64'd1 << 23)) >> 24;
        if (total > 65535) total = 65535;
        return total[OUT_W-1:0];
    endfunction

    // Queue the results that the request at the current position completes.
    function automatic void queue_ready_blurs();
        int w;
        int h;
        int r;
        int first;
        int last;
        res_t res;
        w = frame_width();
        h = frame_height();
        if (row_pos < KERNEL_RADIUS) return;
        r = row_pos - KERNEL_RADIUS;
        if (int'(col_pos) < w - 1)
        begin
            if (col_pos < KERNEL_RADIUS) return;
            first = col_pos - KERNEL_RADIUS;
            last  = first;
        end
        else
        begin
            first = (w - 1 - KERNEL_RADIUS < 0) ? 0 : w - 1 - KERNEL_RADIUS;
            last  = w - 1;
        end
        for (int c = first; c <= last; c++)
        begin
            res.blurred   = window_blur(r, c, w, h);
            res.row_end   = (c == w - 1);
            res.frame_end = (c == w - 1) && (r == h - 1);
            pending_blur.push_back(res);
        end
    endfunction

    function automatic void move_on();
        col_pos++;
        if (int'(col_pos) >= frame_width())
        begin
            col_pos = 0;
            row_pos++;
        end
    endfunction

    function automatic void rewind_frame();
        col_pos = 0;
        row_pos = 0;
    endfunction

    // Predict the effect of one accepted request.
    function automatic void blur_request(op_t op, logic [PIX_W-1:0] value);
        int h;
        h = frame_height();
        if (op == OP_PIXEL)
        begin
            if (int'(row_pos) >= h) rewind_frame();
            line_rows[row_pos % ROWS_KEPT][col_pos] = value;
            queue_ready_blurs();
            move_on();
        end
        else if (int'(row_pos) >= h)
        begin
            queue_ready_blurs();
            move_on();
            if (int'(row_pos) >= h + KERNEL_RADIUS) rewind_frame();
        end
    endfunction

    // Receiver: stalls at random according to the current phase.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_stall <= 1'b0;
        else
            res_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    // Results are sampled at the falling edge, where valid and stall are stable,
    // and are taken at the following rising edge.
    always @(negedge clk)
    begin
        res_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_blur.size() == 0)
            begin
                fail_count++;
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result blurred=%0d row_end=%0b frame_end=%0b",
                             blurred, row_end, frame_end);
            end
            else
            begin
                want = pending_blur.pop_front();
                if (blurred !== want.blurred || row_end !== want.row_end
                    || frame_end !== want.frame_end)
                begin
                    fail_count++;
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                                 want.blurred, want.row_end, want.frame_end,
                                 blurred, row_end, frame_end);
                end
            end
        end
    end

    // Send one request; the predictor is updated at the edge that accepts it.
    task automatic send_request(op_t op, logic [PIX_W-1:0] value);
        bit taken;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            pix_valid <= 1'b0;
            @(posedge clk);
        end
        pix_valid <= 1'b1;
        operation <= op;
        pixel     <= value;
        do
        begin
            @(negedge clk);
            taken = !pix_stall;
            @(posedge clk);
        end
        while (!taken);
        blur_request(op, value);
        requests_sent++;
    endtask

    // Wait until every expected result has arrived, then let the pipeline settle.
    task automatic wait_until_idle();
        pix_valid <= 1'b0;
        while (pending_blur.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // APB write: setup cycle, then the access cycle in which the register is written.
    task automatic write_register(reg_index_t idx, logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * int'(idx));
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_WIDTH:  begin width_reg  = value[CFG_W-1:0]; rewind_frame(); end
            REG_HEIGHT: begin height_reg = value[CFG_W-1:0]; rewind_frame(); end
            REG_CENTER: centre_tap = value[TAP_W-1:0];
            REG_NEAR:   near_tap   = value[TAP_W-1:0];
            REG_FAR:    far_tap    = value[TAP_W-1:0];
            default:    ;
        endcase
    endtask

    function automatic logic [TAP_W-1:0] random_tap();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return TAP_W'($urandom_range(4000, 26000));
        endcase
    endfunction

    function automatic logic [PIX_W-1:0] random_pixel();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom_range(255));
        endcase
    endfunction

    // One frame with random content. Now and then a stray drain request lands
    // inside the frame, or the drain is cut short by the next frame.
    task automatic random_frame();
        int w;
        int h;
        int drains;
        w = frame_width();
        h = frame_height();
        for (int p = 0; p < w * h; p++)
        begin
            if ($urandom_range(19) == 0) send_request(OP_DRAIN, PIX_W'($urandom_range(255)));
            send_request(OP_PIXEL, random_pixel());
        end
        drains = KERNEL_RADIUS * w;
        if ($urandom_range(9) == 0) drains = $urandom_range(drains - 1);
        for (int d = 0; d < drains; d++)
            send_request(OP_DRAIN, PIX_W'($urandom_range(255)));
    endtask

    // Rows of the directed part. A typed row carries a result that can be read
    // straight off the arithmetic: a single-pixel frame under simple taps.
    typedef struct {
        bit               is_reg;
        reg_index_t       idx;
        logic [DATA_W-1:0] value;
        op_t              op;
        logic [PIX_W-1:0] pix;
        bit               typed;
        logic [OUT_W-1:0] typed_blur;
    } step_row_t;

    step_row_t steps[$];

    function automatic void add_reg(reg_index_t idx, logic [DATA_W-1:0] value);
        steps.push_back('{1'b1, idx, value, OP_PIXEL, '0, 1'b0, '0});
    endfunction

    function automatic void add_req(op_t op, logic [PIX_W-1:0] pix);
        steps.push_back('{1'b0, REG_WIDTH, '0, op, pix, 1'b0, '0});
    endfunction

    function automatic void add_typed(op_t op, logic [PIX_W-1:0] pix, logic [OUT_W-1:0] blur);
        steps.push_back('{1'b0, REG_WIDTH, '0, op, pix, 1'b1, blur});
    endfunction

    initial
    begin
        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        pix_valid = 1'b0;
        operation = OP_PIXEL;
        pixel     = '0;
        fail_count         = 0;
        mismatch_count     = 0;
        requests_sent      = 0;
        sender_idle_pct    = 7;
        receiver_stall_pct = 76;
        rewind_frame();
        width_reg  = WIDTH_RESET;
        height_reg = HEIGHT_RESET;
        centre_tap = CENTER_RESET;
        near_tap   = NEAR_RESET;
        far_tap    = FAR_RESET;

        // Single-pixel frame, centre tap only: the pixel scaled by the tap squared.
        add_reg(REG_WIDTH, 1);
        add_reg(REG_HEIGHT, 1);
        add_reg(REG_CENTER, 65535);
        add_reg(REG_NEAR, 0);
        add_reg(REG_FAR, 0);
        add_req(OP_PIXEL, 255);
        add_req(OP_DRAIN, 0);
        add_typed(OP_DRAIN, 0, 16'd65278);
        // All taps zero give a black output.
        add_reg(REG_CENTER, 0);
        add_req(OP_PIXEL, 200);
        add_req(OP_DRAIN, 0);
        add_typed(OP_DRAIN, 0, 16'd0);
        // Full taps everywhere saturate.
        add_reg(REG_CENTER, 65535);
        add_reg(REG_NEAR, 65535);
        add_reg(REG_FAR, 65535);
        add_req(OP_PIXEL, 255);
        add_req(OP_DRAIN, 0);
        add_typed(OP_DRAIN, 0, 16'd65535);
        // Zero sizes are taken as one.
        add_reg(REG_WIDTH, 0);
        add_reg(REG_HEIGHT, 0);
        add_reg(REG_CENTER, CENTER_RESET);
        add_reg(REG_NEAR, NEAR_RESET);
        add_reg(REG_FAR, FAR_RESET);
        add_req(OP_PIXEL, 0);
        add_req(OP_DRAIN, 255);
        add_req(OP_DRAIN, 255);
        // A 3x2 frame: a stray drain inside the frame is ignored, and a pixel
        // part-way through the drain abandons it and opens a new frame.
        add_reg(REG_WIDTH, 3);
        add_reg(REG_HEIGHT, 2);
        add_req(OP_PIXEL, 0);
        add_req(OP_DRAIN, 0);
        add_req(OP_PIXEL, 255);
        add_req(OP_PIXEL, 17);
        add_req(OP_PIXEL, 128);
        add_req(OP_PIXEL, 1);
        add_req(OP_PIXEL, 254);
        add_req(OP_DRAIN, 0);
        add_req(OP_DRAIN, 0);
        add_req(OP_PIXEL, 9);
        // Oversized settings are clamped to the largest frame.
        add_reg(REG_WIDTH, 2047);
        add_reg(REG_HEIGHT, 2047);
        add_req(OP_PIXEL, 255);
        add_req(OP_PIXEL, 0);
        add_req(OP_PIXEL, 255);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (steps[k])
        begin
            if (steps[k].is_reg)
            begin
                wait_until_idle();
                write_register(steps[k].idx, steps[k].value);
            end
            else
            begin
                send_request(steps[k].op, steps[k].pix);
                if (steps[k].typed && pending_blur.size() != 0)
                    pending_blur[$].blurred = steps[k].typed_blur;
            end
        end

        // Random frames in three idling phases; the first opens with fresh settings, and
        // later frames get fresh ones at random, once the block has gone quiet.
        requests_sent = 0;
        for (int phase = 0; phase < 3; phase++)
        begin
            sender_idle_pct    = (phase == 0) ? 7 : (phase == 1) ? 76 : 0;
            receiver_stall_pct = (phase == 0) ? 76 : (phase == 1) ? 7 : 0;
            while (requests_sent < RANDOM_REQS * (phase + 1) / 3)
            begin
                if ($urandom_range(1) == 0 || requests_sent == RANDOM_REQS * phase / 3)
                begin
                    wait_until_idle();
                    write_register(REG_WIDTH, DATA_W'($urandom_range(1, 9)));
                    write_register(REG_HEIGHT, DATA_W'($urandom_range(1, 6)));
                    write_register(REG_CENTER, random_tap());
                    write_register(REG_NEAR, random_tap());
                    write_register(REG_FAR, random_tap());
                end
                random_frame();
            end
        end

        wait_until_idle();
        if (fail_count == 0)
            $display("separable_gaussian_blur verification clean");
        else
            $display("separable_gaussian_blur verification failed");
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial
    begin
        #5ms;
        $display("separable_gaussian_blur verification failed");
        $finish;
    end

endmodule
